[hdl/aul_pkg.sv]
// Package for the audio upsampler with one-pole low-pass.
// Holds beat structs, register indexes, sequencer states and shared constants.
// No dependencies.
`default_nettype none

package aul_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int ALPHA_BITS_DEF = 16;
	localparam int FRAC_BITS      = 8;
	localparam int SAMPLE_W       = 16;
	localparam int STEP_W         = 16;
	localparam int MAX_OUT        = 64;
	localparam int RUN_W          = $clog2(MAX_OUT + 1);
	localparam int CFG_IDX_W      = 2;

	localparam logic [STEP_W-1:0] STEP_RESET = 16'h0100;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd3;

	typedef struct packed {
		logic [7:0] byte_sample;
		logic       sound_start;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic                       run_last;
		logic                       sound_done;
	} out_item_t;

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL0,
		ST_MUL1,
		ST_WAIT,
		ST_FIN,
		ST_EMIT
	} seq_state_t;

endpackage

`default_nettype wire

[hdl/aul_mac.sv]
// Shared signed multiply-accumulate unit for the low-pass filter.
// Registered product, then accumulate; uses aul_pkg::mac_ctl_t.
`default_nettype none

module aul_mac #(
	parameter int CW = aul_pkg::ALPHA_BITS_DEF + 2,
	parameter int DW = aul_pkg::SAMPLE_W
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire aul_pkg::mac_ctl_t   ctl,
	input  wire logic signed [CW-1:0] coef,
	input  wire logic signed [DW-1:0] operand,
	output logic signed [CW+DW:0]    acc
);

	logic signed [CW+DW-1:0] prod_q;
	logic signed [CW+DW:0]   acc_q;
	logic                    vld_q;
	logic                    clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			clr_q <= 1'b0;
		end else begin
			vld_q <= ctl.en;
			clr_q <= ctl.clr;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_q <= coef * operand;
		end
		if (vld_q) begin
			// first product of a pair starts a fresh sum
			acc_q <= (clr_q ? '0 : acc_q) + {prod_q[CW+DW-1], prod_q};
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

[hdl/audio_upsample_lowpass.sv]
// Top level: nearest-neighbor upsampler with one-pole low-pass filter.
// Depends on aul_pkg and aul_mac.
`default_nettype none

// Each accepted byte sample yields zero to 64 output beats, one for every
// output index whose (COUNT_BITS+8).8 source position falls at or before
// this sample's index, up to output_count per sound. A small sequencer
// drives one shared multiply-accumulate unit twice per filtered output,
// stepping through ST_EVAL, ST_MUL0, ST_MUL1, ST_WAIT, ST_FIN and ST_EMIT;
// an output that is the first of a sound or runs with the filter bypassed
// skips the multiply states, and out_stall holds a result in ST_EMIT.
// in_stall stays high from acceptance until the last beat of that input is
// taken. Configuration writes apply at once and belong to idle periods only.
module audio_upsample_lowpass #(
	parameter int COUNT_BITS = aul_pkg::COUNT_BITS_DEF,
	parameter int ALPHA_BITS = aul_pkg::ALPHA_BITS_DEF,
	localparam int CFG_W = (COUNT_BITS > ALPHA_BITS + 1)
		? ((COUNT_BITS > aul_pkg::STEP_W) ? COUNT_BITS : aul_pkg::STEP_W)
		: ((ALPHA_BITS + 1 > aul_pkg::STEP_W) ? ALPHA_BITS + 1 : aul_pkg::STEP_W)
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_write,
	input  wire logic [aul_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]                 cfg_data,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire aul_pkg::in_item_t                in_data,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output aul_pkg::out_item_t                    out_data
);

	localparam int SW    = aul_pkg::SAMPLE_W;
	localparam int POS_W = COUNT_BITS + 16;
	localparam int AW    = ALPHA_BITS + 1;
	localparam int CW    = ALPHA_BITS + 2;
	localparam int MW    = CW + SW + 1;
	localparam logic [AW-1:0] ALPHA_ONE = AW'(1) << ALPHA_BITS;
	localparam logic [MW-1:0] ROUND_BIAS = (MW'(1) << ALPHA_BITS) - MW'(1);

	// configuration
	logic [aul_pkg::STEP_W-1:0] step_q;
	logic [COUNT_BITS-1:0]      count_q;
	logic [AW-1:0]              alpha_q;
	logic                       fen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= aul_pkg::STEP_RESET;
			count_q <= '0;
			alpha_q <= ALPHA_ONE;
			fen_q   <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				aul_pkg::REG_STEP_RATIO:    step_q  <= cfg_data[aul_pkg::STEP_W-1:0];
				aul_pkg::REG_OUTPUT_COUNT:  count_q <= cfg_data[COUNT_BITS-1:0];
				aul_pkg::REG_FILTER_ALPHA:  alpha_q <= cfg_data[AW-1:0];
				aul_pkg::REG_FILTER_ENABLE: fen_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sound state
	aul_pkg::seq_state_t state_q, state_d;
	logic [COUNT_BITS-1:0]       out_idx_q;
	logic [POS_W-1:0]            pos_q;
	logic [COUNT_BITS-1:0]       in_idx_q;
	logic signed [SW-1:0]        prev_q;
	logic signed [SW-1:0]        x_q;
	logic [aul_pkg::RUN_W-1:0]   run_q;
	logic                        has_res_q;
	logic                        cont_q;
	logic signed [SW-1:0]        y_q;
	logic                        done_q;

	logic                        accept_in;
	logic                        accept_out;
	logic                        more;
	logic                        bypass;
	logic [AW-1:0]               alpha_eff;
	logic [COUNT_BITS-1:0]       idx_inc;
	logic signed [SW-1:0]        y_new;
	logic signed [MW-1:0]        acc;
	logic [MW-1:0]               biased;
	aul_pkg::mac_ctl_t           mac_ctl;
	logic signed [CW-1:0]        mac_coef;
	logic signed [SW-1:0]        mac_operand;

	assign accept_in  = in_valid && !in_stall;
	assign accept_out = out_valid && !out_stall;
	assign alpha_eff  = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign idx_inc    = out_idx_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
	assign bypass     = (out_idx_q == '0) || !fen_q;

	assign more = (run_q < aul_pkg::RUN_W'(aul_pkg::MAX_OUT)) && (out_idx_q < count_q) &&
		(pos_q[POS_W-1:aul_pkg::FRAC_BITS] <=
		 {{(POS_W-aul_pkg::FRAC_BITS-COUNT_BITS){1'b0}}, in_idx_q});

	// truncate toward zero: bias negative sums before the arithmetic shift
	assign biased = acc + (acc[MW-1] ? ROUND_BIAS : '0);
	assign y_new  = bypass ? x_q : biased[ALPHA_BITS +: SW];

	assign mac_coef    = (state_q == aul_pkg::ST_MUL0) ? {1'b0, alpha_eff}
		: {1'b0, ALPHA_ONE - alpha_eff};
	assign mac_operand = (state_q == aul_pkg::ST_MUL0) ? x_q : prev_q;

	aul_mac #(
		.CW(CW),
		.DW(SW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (mac_coef),
		.operand(mac_operand),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aul_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mac_ctl.en  = 1'b0;
		mac_ctl.clr = 1'b0;
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		case (state_q)
			aul_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = aul_pkg::ST_EVAL;
				end
			end
			aul_pkg::ST_EVAL: begin
				if (has_res_q) begin
					state_d = aul_pkg::ST_EMIT;
				end else if (more) begin
					state_d = bypass ? aul_pkg::ST_FIN : aul_pkg::ST_MUL0;
				end else begin
					state_d = aul_pkg::ST_IDLE;
				end
			end
			aul_pkg::ST_MUL0: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.clr = 1'b1;
				state_d     = aul_pkg::ST_MUL1;
			end
			aul_pkg::ST_MUL1: begin
				mac_ctl.en = 1'b1;
				state_d    = aul_pkg::ST_WAIT;
			end
			aul_pkg::ST_WAIT: state_d = aul_pkg::ST_FIN;
			aul_pkg::ST_FIN:  state_d = aul_pkg::ST_EVAL;
			aul_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (cont_q) begin
						state_d = bypass ? aul_pkg::ST_FIN : aul_pkg::ST_MUL0;
					end else begin
						state_d = aul_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = aul_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_idx_q <= '0;
			pos_q     <= '0;
			in_idx_q  <= '0;
			prev_q    <= '0;
			run_q     <= '0;
			has_res_q <= 1'b0;
			cont_q    <= 1'b0;
		end else begin
			case (state_q)
				aul_pkg::ST_IDLE: begin
					if (accept_in) begin
						run_q     <= '0;
						has_res_q <= 1'b0;
						if (in_data.sound_start) begin
							out_idx_q <= '0;
							pos_q     <= '0;
							in_idx_q  <= '0;
							prev_q    <= '0;
						end
					end
				end
				aul_pkg::ST_EVAL: begin
					if (has_res_q) begin
						cont_q <= more;
					end else if (!more) begin
						in_idx_q <= in_idx_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
					end
				end
				aul_pkg::ST_FIN: begin
					prev_q    <= y_new;
					out_idx_q <= idx_inc;
					pos_q     <= pos_q + {{(POS_W-aul_pkg::STEP_W){1'b0}}, step_q};
					run_q     <= run_q + {{(aul_pkg::RUN_W-1){1'b0}}, 1'b1};
					has_res_q <= 1'b1;
				end
				aul_pkg::ST_EMIT: begin
					// last beat of this input: advance the source index
					if (accept_out && !cont_q) begin
						in_idx_q <= in_idx_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept_in) begin
			x_q <= {in_data.byte_sample ^ 8'h80, in_data.byte_sample};
		end
		if (state_q == aul_pkg::ST_FIN) begin
			y_q    <= y_new;
			done_q <= (idx_inc == count_q);
		end
	end

	assign out_data.left_sample  = y_q;
	assign out_data.right_sample = y_q;
	assign out_data.run_last     = !cont_q;
	assign out_data.sound_done   = done_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result beat is pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.sound_done) |-> out_data.run_last)
		else $error("final beat of a sound not marked as last of its input");

	assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= aul_pkg::RUN_W'(aul_pkg::MAX_OUT))
		else $error("too many results for one input");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept_out && out_data.run_last) |=> (state_q == aul_pkg::ST_IDLE))
		else $error("sequencer did not return to idle after last beat");

endmodule

`default_nettype wire

[bench/audio_upsample_lowpass_tb.sv]
// Testbench for audio_upsample_lowpass: directed and random sounds across many register
// settings, with random gaps on both beat channels and a self-checking output scoreboard.
// Depends on aul_pkg and the audio_upsample_lowpass RTL.
`timescale 1ns / 100ps

module audio_upsample_lowpass_tb;

	localparam int CFG_W         = aul_pkg::COUNT_BITS_DEF;	// widest register is output_count
	localparam int ALPHA_ONE     = 1 << aul_pkg::ALPHA_BITS_DEF;
	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 16;

	typedef enum int {
		GAPS_NONE,
		GAPS_SENDER,
		GAPS_RECEIVER,
		GAPS_BOTH
	} gap_mode_t;

	// Tracks resampler and filter state, queues the samples each input beat makes due
	// and checks output beats against them in order.
	class upsample_checker;
		logic [aul_pkg::STEP_W-1:0]          step_ratio;
		logic [aul_pkg::COUNT_BITS_DEF-1:0]  out_count;
		logic [aul_pkg::ALPHA_BITS_DEF:0]    alpha;
		logic                                filter_on;
		logic [aul_pkg::COUNT_BITS_DEF-1:0]  out_idx;
		logic [aul_pkg::COUNT_BITS_DEF+15:0] src_pos;
		logic [aul_pkg::COUNT_BITS_DEF-1:0]  in_idx;
		longint                              prev_y;
		aul_pkg::out_item_t                  due[$];
		int                                  errors;

		function new();
			step_ratio = aul_pkg::STEP_RESET;
			out_count = '0;
			alpha = 17'(ALPHA_ONE);
			filter_on = 1'b1;
			errors = 0;
			clear_sound();
		endfunction

		function void clear_sound();
			out_idx = '0;
			src_pos = '0;
			in_idx = '0;
			prev_y = 0;
		endfunction

		function void set_reg(logic [aul_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
			aul_pkg::REG_STEP_RATIO:    step_ratio = value[aul_pkg::STEP_W-1:0];
			aul_pkg::REG_OUTPUT_COUNT:  out_count = value[aul_pkg::COUNT_BITS_DEF-1:0];
			aul_pkg::REG_FILTER_ALPHA:  alpha = value[aul_pkg::ALPHA_BITS_DEF:0];
			aul_pkg::REG_FILTER_ENABLE: filter_on = value[0];
			default: ;
			endcase
		endfunction

		function void take_input(aul_pkg::in_item_t beat);
			longint             x, y, a, acc;
			int                 n;
			aul_pkg::out_item_t sample;
			x = longint'(beat.byte_sample) * 257 - 32768;
			if (beat.sound_start)
				clear_sound();
			n = 0;
			while (n < aul_pkg::MAX_OUT && out_idx < out_count &&
					(src_pos >> aul_pkg::FRAC_BITS) <= in_idx) begin
				if (out_idx == 0 || !filter_on) begin
					y = x;
				end else begin
					// clamp alpha at 1.0; signed divide truncates toward zero
					a = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
					acc = a * x + (ALPHA_ONE - a) * prev_y;
					y = acc / ALPHA_ONE;
				end
				prev_y = y;
				sample.left_sample = y[15:0];
				sample.right_sample = y[15:0];
				sample.run_last = 1'b0;
				sample.sound_done = (out_idx + 1 == out_count);
				due.push_back(sample);
				out_idx++;
				src_pos += step_ratio;
				n++;
			end
			if (n > 0) begin
				sample = due.pop_back();
				sample.run_last = 1'b1;
				due.push_back(sample);
			end
			in_idx++;
		endfunction

		function void compare_field(string field, longint want, longint got);
			if (want != got) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_output(aul_pkg::out_item_t got);
			aul_pkg::out_item_t want;
			if (due.size() == 0) begin
				$display("%0t: unexpected output beat: expected none, actual %0d %0d %0b %0b",
					$time, got.left_sample, got.right_sample, got.run_last, got.sound_done);
				errors++;
				return;
			end
			want = due.pop_front();
			compare_field("left_sample", want.left_sample, got.left_sample);
			compare_field("right_sample", want.right_sample, got.right_sample);
			compare_field("run_last", want.run_last, got.run_last);
			compare_field("sound_done", want.sound_done, got.sound_done);
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_write;
	logic [aul_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]              cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	aul_pkg::in_item_t             in_data;
	logic                          out_valid;
	logic                          out_stall;
	aul_pkg::out_item_t            out_data;

	int send_gap_pct = 0;
	int stall_pct = 0;

	upsample_checker model;

	audio_upsample_lowpass u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			model.check_output(out_data);
	end

	// End the run if no beat moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic set_gaps(gap_mode_t mode);
		case (mode)
		GAPS_NONE: begin
			send_gap_pct = 0;
			stall_pct = 0;
		end
		GAPS_SENDER: begin
			send_gap_pct = 47;
			stall_pct = 0;
		end
		GAPS_RECEIVER: begin
			send_gap_pct = 0;
			stall_pct = 47;
		end
		GAPS_BOTH: begin
			send_gap_pct = 31;
			stall_pct = 31;
		end
		default: begin
			send_gap_pct = 0;
			stall_pct = 0;
		end
		endcase
	endtask

	task automatic write_reg(logic [aul_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		model.set_reg(idx, value);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic write_all(logic [15:0] ratio, logic [23:0] count, logic [16:0] alpha,
			logic enable);
		write_reg(aul_pkg::REG_STEP_RATIO, CFG_W'(ratio));
		write_reg(aul_pkg::REG_OUTPUT_COUNT, CFG_W'(count));
		write_reg(aul_pkg::REG_FILTER_ALPHA, CFG_W'(alpha));
		write_reg(aul_pkg::REG_FILTER_ENABLE, CFG_W'(enable));
	endtask

	task automatic send_sample(logic [7:0] value, logic start);
		aul_pkg::in_item_t beat;
		beat.byte_sample = value;
		beat.sound_start = start;
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall);
		model.take_input(beat);
	endtask

	// Drop valid, wait for every due sample, then let a zero-output input finish.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (model.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(int items);
		bit          fresh;
		logic [15:0] ratio;
		logic [23:0] count;
		logic [16:0] alpha;
		fresh = ($urandom_range(3) != 0);
		case ($urandom_range(9))
		0:       ratio = 16'($urandom_range(4, 63));
		1:       ratio = 16'($urandom_range(1024, 65535));
		2:       ratio = 16'hFFFF;
		default: ratio = 16'($urandom_range(64, 1023));
		endcase
		case ($urandom_range(9))
		0:       count = '0;
		1:       count = 24'hFFFFFF;
		2:       count = 24'($urandom_range(1, 8));
		default: count = 24'($urandom_range(9, 600));
		endcase
		case ($urandom_range(9))
		0:       alpha = '0;
		1:       alpha = 17'(ALPHA_ONE);
		2:       alpha = 17'($urandom_range(ALPHA_ONE + 1, 2 * ALPHA_ONE - 1));
		default: alpha = 17'($urandom_range(1, ALPHA_ONE - 1));
		endcase
		if (fresh)
			write_all(ratio, count, alpha, $urandom_range(4) != 0);
		else if ($urandom_range(1))
			write_reg(aul_pkg::REG_STEP_RATIO, CFG_W'(ratio));
		else
			write_reg(aul_pkg::REG_OUTPUT_COUNT,
				CFG_W'($urandom_range(0, model.out_idx + 40)));
		for (int i = 0; i < items; i++)
			send_sample(8'($urandom_range(255)), (fresh && i == 0) || ($urandom_range(99) < 4));
		drain();
	endtask

	initial begin
		model = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// output_count resets to zero: nothing comes out
		set_gaps(GAPS_NONE);
		send_sample(8'd128, 1'b1);
		send_sample(8'd7, 1'b0);
		drain();

		// sample extremes at 1:1, count reached one input before the last
		write_all(16'd256, 24'd6, 17'(ALPHA_ONE), 1'b1);
		send_sample(8'd0, 1'b1);
		send_sample(8'd255, 1'b0);
		send_sample(8'd128, 1'b0);
		send_sample(8'd1, 1'b0);
		send_sample(8'd254, 1'b0);
		send_sample(8'd127, 1'b0);
		send_sample(8'd200, 1'b0);
		drain();

		// smallest ratio: full 64-beat runs; alpha zero holds the first value
		set_gaps(GAPS_RECEIVER);
		write_all(16'd4, 24'd200, 17'd0, 1'b1);
		send_sample(8'd255, 1'b1);
		send_sample(8'd0, 1'b0);
		send_sample(8'd0, 1'b0);
		send_sample(8'd0, 1'b0);
		drain();

		// alpha above one acts as one
		set_gaps(GAPS_SENDER);
		write_all(16'd512, 24'd50, 17'h1FFFF, 1'b1);
		send_sample(8'd10, 1'b1);
		send_sample(8'd240, 1'b0);
		send_sample(8'd30, 1'b0);
		send_sample(8'd200, 1'b0);
		drain();

		// filter bypass, then filter switched on mid-sound
		set_gaps(GAPS_BOTH);
		write_all(16'd100, 24'd1000, 17'd30000, 1'b0);
		send_sample(8'd77, 1'b1);
		send_sample(8'd200, 1'b0);
		send_sample(8'd3, 1'b0);
		drain();
		write_reg(aul_pkg::REG_FILTER_ENABLE, CFG_W'(1'b1));
		send_sample(8'd250, 1'b0);
		send_sample(8'd128, 1'b0);
		drain();

		// largest ratio and count
		set_gaps(GAPS_NONE);
		write_all(16'hFFFF, 24'hFFFFFF, 17'd40000, 1'b1);
		send_sample(8'd99, 1'b1);
		send_sample(8'd1, 1'b0);
		drain();

		for (int p = 0; p < 12; p++) begin
			set_gaps(gap_mode_t'(p % 4));
			random_phase(28);
		end

		if (model.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
